[hdl/i2a_pkg.sv]
// ----------------------------------------------------------------------------
// i2a_pkg
// types, constants and helpers shared by the integer to ascii formatter
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int unsigned VALUE_W     = 32;
    localparam int unsigned CHAR_W      = 8;
    localparam int unsigned MAX_CHARS   = 11;
    localparam int unsigned QUEUE_DEPTH = 2;

    // operation codes
    localparam logic [1:0] OP_SDEC = 2'd0;
    localparam logic [1:0] OP_UDEC = 2'd1;
    localparam logic [1:0] OP_HEXL = 2'd2;
    localparam logic [1:0] OP_HEXU = 2'd3;

    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    // reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> RECIP10_SHIFT
    localparam logic [VALUE_W-1:0] RECIP10       = 32'hCCCC_CCCD;
    localparam int unsigned        RECIP10_SHIFT = 35;

    typedef struct packed {
        logic [1:0]         op;
        logic [VALUE_W-1:0] value;
    } in_item_t;

    typedef struct packed {
        logic [CHAR_W-1:0]  character;
        logic               last;
        logic [VALUE_W-1:0] total_written;
    } out_item_t;

    // classified command handed from front to back
    typedef struct packed {
        logic [VALUE_W-1:0] mag;
        logic               neg;
        logic               hex;
        logic               upper;
    } cmd_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_DIGIT,
        B_SIGN,
        B_EMIT
    } back_state_t;

    // ascii for one digit, decimal or hex, in either case
    function automatic logic [CHAR_W-1:0] digit_char(input logic [3:0] d, input logic upper);
        logic [CHAR_W-1:0] c;
        begin
            if (d < 4'd10)
            begin
                c = CHAR_ZERO + {4'd0, d};
            end
            else if (upper)
            begin
                c = 8'h37 + {4'd0, d};
            end
            else
            begin
                c = 8'h57 + {4'd0, d};
            end
            return c;
        end
    endfunction

endpackage

[hdl/i2a_front.sv]
// ----------------------------------------------------------------------------
// i2a_front
// accepts an operand, works out sign and magnitude, hands a command on
// ----------------------------------------------------------------------------
module i2a_front
(
    input  i2a_pkg::in_item_t request,
    input  logic              push,
    output logic              full,
    input  logic              q_full,
    output logic              enq,
    output i2a_pkg::cmd_t     cmd
);

    logic neg;

    assign full = q_full;
    assign enq  = push & ~q_full;

    // signed mode with the top bit set: magnitude by unsigned negation
    assign neg = (request.op == i2a_pkg::OP_SDEC) & request.value[i2a_pkg::VALUE_W-1];

    always_comb
    begin
        cmd.neg   = neg;
        cmd.mag   = neg ? (~request.value + 1'b1) : request.value;
        cmd.hex   = (request.op == i2a_pkg::OP_HEXL) | (request.op == i2a_pkg::OP_HEXU);
        cmd.upper = (request.op == i2a_pkg::OP_HEXU);
    end

endmodule

[hdl/i2a_queue.sv]
// ----------------------------------------------------------------------------
// i2a_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module i2a_queue
#(
    parameter int unsigned DEPTH = i2a_pkg::QUEUE_DEPTH
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          enq,
    input  i2a_pkg::cmd_t enq_cmd,
    output logic          q_full,
    input  logic          deq,
    output logic          q_valid,
    output i2a_pkg::cmd_t deq_cmd
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR   = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    i2a_pkg::cmd_t entry_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;

    assign q_full  = (count_reg == FULL_COUNT);
    assign q_valid = (count_reg != '0);
    assign deq_cmd = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (enq)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (deq)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (enq && !deq)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (deq && !enq)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            entry_reg[wr_ptr_reg] <= enq_cmd;
        end
    end

endmodule

[hdl/i2a_back.sv]
// ----------------------------------------------------------------------------
// i2a_back
// digit generation into a character buffer, then emission msb first
// ----------------------------------------------------------------------------
module i2a_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_valid,
    input  i2a_pkg::cmd_t      deq_cmd,
    output logic               deq,
    output i2a_pkg::out_item_t result,
    output logic               empty,
    input  logic               pop
);

    localparam int unsigned VW = i2a_pkg::VALUE_W;
    localparam int unsigned BW = $clog2(i2a_pkg::MAX_CHARS + 1);

    i2a_pkg::back_state_t state_reg, state_next;

    logic [VW-1:0]               mag_reg;
    logic                        neg_reg;
    logic                        hex_reg;
    logic                        upper_reg;
    logic [BW-1:0]               cnt_reg;
    logic [i2a_pkg::CHAR_W-1:0]  buf_reg [i2a_pkg::MAX_CHARS];
    logic                        out_valid_reg;
    i2a_pkg::out_item_t          out_reg;
    logic [VW-1:0]               total_reg;

    logic [2*VW-1:0]             prod;
    logic [VW-1:0]               quo;
    logic [3:0]                  dig;
    logic [3:0]                  q_low_x10;
    logic                        buf_wr;
    logic                        out_load;
    logic [i2a_pkg::CHAR_W-1:0]  wr_char;
    logic [BW-1:0]               rd_idx;

    // one digit per cycle: divide by ten through the reciprocal, or shift by four
    assign prod      = mag_reg * i2a_pkg::RECIP10;
    assign q_low_x10 = {prod[i2a_pkg::RECIP10_SHIFT+2:i2a_pkg::RECIP10_SHIFT], 1'b0}
                     + {prod[i2a_pkg::RECIP10_SHIFT:i2a_pkg::RECIP10_SHIFT], 3'b000};

    always_comb
    begin
        if (hex_reg)
        begin
            quo = {4'd0, mag_reg[VW-1:4]};
            dig = mag_reg[3:0];
        end
        else
        begin
            quo = VW'(prod[2*VW-1:i2a_pkg::RECIP10_SHIFT]);
            dig = mag_reg[3:0] - q_low_x10;
        end
    end

    assign rd_idx = cnt_reg - 1'b1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            i2a_pkg::B_IDLE:
            begin
                if (q_valid)
                begin
                    state_next = i2a_pkg::B_DIGIT;
                end
            end
            i2a_pkg::B_DIGIT:
            begin
                if (quo == '0)
                begin
                    state_next = neg_reg ? i2a_pkg::B_SIGN : i2a_pkg::B_EMIT;
                end
            end
            i2a_pkg::B_SIGN:
            begin
                state_next = i2a_pkg::B_EMIT;
            end
            i2a_pkg::B_EMIT:
            begin
                if (out_load && cnt_reg == BW'(1))
                begin
                    state_next = i2a_pkg::B_IDLE;
                end
            end
            default:
            begin
                state_next = i2a_pkg::B_IDLE;
            end
        endcase
    end

    // outputs of the state machine
    always_comb
    begin
        deq      = 1'b0;
        buf_wr   = 1'b0;
        out_load = 1'b0;
        wr_char  = i2a_pkg::digit_char(dig, upper_reg);
        unique case (state_reg)
            i2a_pkg::B_IDLE:
            begin
                deq = q_valid;
            end
            i2a_pkg::B_DIGIT:
            begin
                buf_wr = 1'b1;
            end
            i2a_pkg::B_SIGN:
            begin
                buf_wr  = 1'b1;
                wr_char = i2a_pkg::CHAR_MINUS;
            end
            i2a_pkg::B_EMIT:
            begin
                out_load = ~out_valid_reg | pop;
            end
            default:
            begin
                deq = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= i2a_pkg::B_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (deq)
            begin
                cnt_reg <= '0;
            end
            else if (buf_wr)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (out_load)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
                total_reg     <= total_reg + 1'b1;
            end
            else if (pop)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (deq)
        begin
            mag_reg   <= deq_cmd.mag;
            neg_reg   <= deq_cmd.neg;
            hex_reg   <= deq_cmd.hex;
            upper_reg <= deq_cmd.upper;
        end
        else if (state_reg == i2a_pkg::B_DIGIT)
        begin
            mag_reg <= quo;
        end
        if (buf_wr)
        begin
            buf_reg[cnt_reg] <= wr_char;
        end
        if (out_load)
        begin
            out_reg.character     <= buf_reg[rd_idx];
            out_reg.last          <= (cnt_reg == BW'(1));
            out_reg.total_written <= total_reg + 1'b1;
        end
    end

    assign result = out_reg;
    assign empty  = ~out_valid_reg;

endmodule

[hdl/integer_to_ascii_formatter.sv]
// flow: an accepted item is registered in the queue, then taken by the back end, which
//   writes its digits, then a minus sign if negative, into the character buffer
// the back end then emits the characters through its output register and takes no new
//   command until the last character of the current one has been loaded there
// reset: rst_n asynchronous, clears the queue, the back end and the character total
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// formats a 32-bit operand as signed/unsigned decimal or hex ascii text
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter
#(
    parameter int unsigned QUEUE_DEPTH = i2a_pkg::QUEUE_DEPTH
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  i2a_pkg::in_item_t  request,
    input  logic               push,
    output logic               full,
    output i2a_pkg::out_item_t result,
    output logic               empty,
    input  logic               pop
);

    // front to queue
    logic          enq;
    i2a_pkg::cmd_t enq_cmd;
    logic          q_full;

    // queue to back
    logic          q_valid;
    logic          deq;
    i2a_pkg::cmd_t deq_cmd;

    // front: classifies the mode and forms the magnitude, one item a cycle while the queue is not full
    i2a_front u_front
    (
        .request (request),
        .push    (push),
        .full    (full),
        .q_full  (q_full),
        .enq     (enq),
        .cmd     (enq_cmd)
    );

    // a few commands wait here while the back end is still printing
    i2a_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .enq     (enq),
        .enq_cmd (enq_cmd),
        .q_full  (q_full),
        .deq     (deq),
        .q_valid (q_valid),
        .deq_cmd (deq_cmd)
    );

    // back: digits least significant first into a buffer, read back in reverse
    // through an output register that holds a waiting item while pop is low
    i2a_back u_back
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .deq_cmd (deq_cmd),
        .deq     (deq),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

endmodule

[hdl/i2a_checker.sv]
// ----------------------------------------------------------------------------
// i2a_checker
// port level checks on the formatter, bound to the top level
// ----------------------------------------------------------------------------
module i2a_checker
(
    input logic               clk,
    input logic               rst_n,
    input i2a_pkg::out_item_t result,
    input logic               empty,
    input logic               pop
);

    // a waiting item holds until taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(result)))
        else $error("result changed while stalled");

    // character total counts up by one per delivered item
    a_total: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop) |=>
        (empty || result.total_written == $past(result.total_written) + 32'd1))
        else $error("character total skipped or repeated");

    // a minus sign is never the final character
    a_minus_last: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && result.character == i2a_pkg::CHAR_MINUS) |-> !result.last)
        else $error("minus sign ends a number");

    // a minus sign only opens a number
    a_minus_first: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !result.last) |=>
        (empty || result.character != i2a_pkg::CHAR_MINUS))
        else $error("minus sign inside a number");

endmodule

bind integer_to_ascii_formatter i2a_checker u_checker
(
    .clk    (clk),
    .rst_n  (rst_n),
    .result (result),
    .empty  (empty),
    .pop    (pop)
);

[test/tb_integer_to_ascii_formatter.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_formatter
// sends numbers in all four modes through the formatter and checks every
// character, its last flag and the running total against a local model
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_formatter;

    localparam int unsigned RANDOM_NUMBERS = 450;
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned TAIL_CYCLES    = 40;
    localparam int unsigned HOLD_CYCLES    = 400;
    localparam int unsigned HOLD_EVERY     = 220;
    localparam int unsigned REPORT_LIMIT   = 10;

    // letters for hex digits above nine
    localparam logic [i2a_pkg::CHAR_W-1:0] HEX_LOWER_A = 8'h61;
    localparam logic [i2a_pkg::CHAR_W-1:0] HEX_UPPER_A = 8'h41;

    // one pending item, optionally held back until all output has drained
    typedef struct {
        i2a_pkg::in_item_t item;
        bit                wait_drain;
    } send_slot_t;

    logic               clk     = 1'b0;
    logic               rst_n   = 1'b0;
    i2a_pkg::in_item_t  request = '0;
    logic               push    = 1'b0;
    logic               full;
    i2a_pkg::out_item_t result;
    logic               empty;
    logic               pop     = 1'b0;

    send_slot_t                  numbers_to_send[$];
    i2a_pkg::out_item_t          expected_chars[$];
    logic [i2a_pkg::VALUE_W-1:0] char_total = '0;

    // these four counters, shared between processes, are written with nonblocking assignments
    int unsigned numbers_sent     = 0;
    int unsigned chars_checked    = 0;
    logic        receiver_holding = 1'b0;
    int unsigned idle_cycles      = 0;

    int unsigned chars_predicted = 0;
    int unsigned mismatches      = 0;
    int unsigned op_seen[4]      = '{default: 0};
    int unsigned send_idle       = 0;
    int unsigned recv_idle       = 0;
    int unsigned hold_left       = 0;
    int unsigned next_hold_at    = 60;

    integer_to_ascii_formatter i_dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .push    (push),
        .full    (full),
        .result  (result),
        .empty   (empty),
        .pop     (pop)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // model of the formatter: builds the text of one number and queues one
    // expected character per output item, counting the running total
    // ------------------------------------------------------------------------
    function automatic void predict_text(input i2a_pkg::in_item_t item);
        logic [i2a_pkg::CHAR_W-1:0]  text[$];
        logic [i2a_pkg::VALUE_W-1:0] mag;
        logic [3:0]                  nib;
        logic [i2a_pkg::CHAR_W-1:0]  letter_a;
        bit                          neg;
        i2a_pkg::out_item_t          want;
        neg = (item.op == i2a_pkg::OP_SDEC) && item.value[i2a_pkg::VALUE_W-1];
        // unsigned negation, so the most negative value keeps its magnitude
        mag = neg ? (32'd0 - item.value) : item.value;
        letter_a = (item.op == i2a_pkg::OP_HEXU) ? HEX_UPPER_A : HEX_LOWER_A;
        op_seen[item.op]++;
        if (mag == '0)
        begin
            text.push_front(i2a_pkg::CHAR_ZERO);
        end
        else if (item.op == i2a_pkg::OP_SDEC || item.op == i2a_pkg::OP_UDEC)
        begin
            while (mag != '0)
            begin
                text.push_front(i2a_pkg::CHAR_ZERO + 8'(mag % 10));
                mag = mag / 10;
            end
        end
        else
        begin
            while (mag != '0)
            begin
                nib = mag[3:0];
                if (nib < 4'd10)
                begin
                    text.push_front(i2a_pkg::CHAR_ZERO + 8'(nib));
                end
                else
                begin
                    text.push_front(letter_a + 8'(nib) - 8'd10);
                end
                mag = mag >> 4;
            end
        end
        if (neg)
        begin
            text.push_front(i2a_pkg::CHAR_MINUS);
        end
        foreach (text[k])
        begin
            char_total = char_total + 1'b1;
            want.character     = text[k];
            want.last          = (k == text.size() - 1);
            want.total_written = char_total;
            expected_chars.push_back(want);
            chars_predicted++;
        end
    endfunction

    // compare one received character with the oldest expectation
    function automatic void check_char(input i2a_pkg::out_item_t got);
        i2a_pkg::out_item_t want;
        if (expected_chars.size() == 0)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("unexpected character %h last %b total %0d",
                         got.character, got.last, got.total_written);
            end
            return;
        end
        want = expected_chars.pop_front();
        if (got.character !== want.character || got.last !== want.last ||
            got.total_written !== want.total_written)
        begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
            begin
                $display("character %0d: expected %h last %b total %0d, got %h last %b total %0d",
                         chars_checked, want.character, want.last, want.total_written,
                         got.character, got.last, got.total_written);
            end
        end
    endfunction

    // idle length: mostly none or short, now and then long
    function automatic int unsigned draw_idle(input bit quiet);
        int unsigned r;
        r = $urandom_range(0, 99);
        if (quiet || r < 55)
        begin
            return 0;
        end
        if (r < 90)
        begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // operand mix: plain random, small values, decimal and hex digit-count edges
    function automatic logic [i2a_pkg::VALUE_W-1:0] pick_value();
        logic [i2a_pkg::VALUE_W-1:0] p;
        int unsigned                 k;
        p = 32'd1;
        k = $urandom_range(0, 9);
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $urandom;
            4: return $urandom_range(0, 20);
            // small negative numbers in two's complement
            5: return 32'd0 - $urandom_range(1, 20);
            // around powers of ten, either sign
            6, 7:
            begin
                repeat (k) p = p * 10;
                p = p + $urandom_range(0, 2) - 1;
                return ($urandom_range(0, 1) != 0) ? p : 32'd0 - p;
            end
            // around powers of sixteen
            8: return (32'd1 << (4 * (k % 8))) - $urandom_range(0, 1);
            // random digit count
            default: return $urandom >> $urandom_range(1, 31);
        endcase
    endfunction

    function automatic void queue_number(input logic [1:0] op,
                                         input logic [i2a_pkg::VALUE_W-1:0] value,
                                         input bit wait_drain);
        send_slot_t slot;
        slot.item.op    = op;
        slot.item.value = value;
        slot.wait_drain = wait_drain;
        numbers_to_send.push_back(slot);
    endfunction

    // ------------------------------------------------------------------------
    // driver: offers the head of the pending queue, keeps it steady while the
    // block is full and predicts its text once the item is taken
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic next_push;
        if (!rst_n)
        begin
            push <= 1'b0;
        end
        else
        begin
            next_push = 1'b0;
            if (push && !full)
            begin
                predict_text(request);
                void'(numbers_to_send.pop_front());
                numbers_sent <= numbers_sent + 1;
                // no gaps while the receiver holds off, so the block backs up, nor in every fourth run of fifty numbers
                send_idle = draw_idle(receiver_holding || (numbers_sent / 50) % 4 == 3);
            end
            if (push && full)
            begin
                next_push = 1'b1;
            end
            else if (send_idle > 0)
            begin
                send_idle--;
            end
            else if (numbers_to_send.size() != 0)
            begin
                // a marked item waits until every predicted character has come back
                if (!numbers_to_send[0].wait_drain || chars_checked == chars_predicted)
                begin
                    next_push = 1'b1;
                    request   <= numbers_to_send[0].item;
                end
            end
            push <= next_push;
        end
    end

    // ------------------------------------------------------------------------
    // monitor: takes characters with random stalls and long hold-offs at
    // fixed points of the run, checking each against the model
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic next_pop;
        if (!rst_n)
        begin
            pop <= 1'b0;
        end
        else
        begin
            if (pop && !empty)
            begin
                check_char(result);
                chars_checked <= chars_checked + 1;
                recv_idle = draw_idle((chars_checked / 150) % 4 == 1);
            end
            if (hold_left == 0 && numbers_sent >= next_hold_at)
            begin
                hold_left    = HOLD_CYCLES;
                next_hold_at = next_hold_at + HOLD_EVERY;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                next_pop = 1'b0;
            end
            else if (recv_idle > 0)
            begin
                recv_idle--;
                next_pop = 1'b0;
            end
            else
            begin
                next_pop = 1'b1;
            end
            pop              <= next_pop;
            receiver_holding <= (hold_left > 0);
        end
    end

    // cycles in a row in which neither side moved an item
    always @(posedge clk)
    begin
        if ((push && !full) || (pop && !empty))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(negedge clk);
        end
        $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------------
    initial
    begin
        // zero in every mode
        queue_number(i2a_pkg::OP_SDEC, 32'h0000_0000, 1'b0);
        queue_number(i2a_pkg::OP_UDEC, 32'h0000_0000, 1'b0);
        queue_number(i2a_pkg::OP_HEXL, 32'h0000_0000, 1'b0);
        queue_number(i2a_pkg::OP_HEXU, 32'h0000_0000, 1'b0);
        // most negative, most positive and small signed values
        queue_number(i2a_pkg::OP_SDEC, 32'h8000_0000, 1'b0);
        queue_number(i2a_pkg::OP_SDEC, 32'h7FFF_FFFF, 1'b0);
        queue_number(i2a_pkg::OP_SDEC, 32'hFFFF_FFFF, 1'b0);
        queue_number(i2a_pkg::OP_SDEC, 32'h0000_0001, 1'b0);
        queue_number(i2a_pkg::OP_SDEC, 32'hFFFF_FFF6, 1'b0);
        // unsigned extremes and digit-count edges
        queue_number(i2a_pkg::OP_UDEC, 32'hFFFF_FFFF, 1'b0);
        queue_number(i2a_pkg::OP_UDEC, 32'h8000_0000, 1'b0);
        queue_number(i2a_pkg::OP_UDEC, 32'd9, 1'b0);
        queue_number(i2a_pkg::OP_UDEC, 32'd10, 1'b0);
        queue_number(i2a_pkg::OP_UDEC, 32'd1000000000, 1'b0);
        queue_number(i2a_pkg::OP_UDEC, 32'd999999999, 1'b0);
        // hex in both cases, every letter, full and short widths
        queue_number(i2a_pkg::OP_HEXL, 32'hDEAD_BEEF, 1'b0);
        queue_number(i2a_pkg::OP_HEXU, 32'hDEAD_BEEF, 1'b0);
        queue_number(i2a_pkg::OP_HEXL, 32'hFFFF_FFFF, 1'b0);
        queue_number(i2a_pkg::OP_HEXU, 32'hABCD_EF01, 1'b0);
        queue_number(i2a_pkg::OP_HEXL, 32'h0000_000F, 1'b0);
        queue_number(i2a_pkg::OP_HEXU, 32'h1000_0000, 1'b0);
        queue_number(i2a_pkg::OP_HEXL, 32'h1234_5678, 1'b0);

        // random part, with the sender draining the block three times
        for (int unsigned n = 0; n < RANDOM_NUMBERS; n++)
        begin
            queue_number(2'($urandom_range(0, 3)), pick_value(), (n % 150) == 0);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // every item taken, then every character back
        do
        begin
            @(negedge clk);
        end
        while (numbers_to_send.size() != 0 || push);
        while (chars_checked != chars_predicted)
        begin
            @(negedge clk);
        end
        // room for any stray character to show up
        repeat (TAIL_CYCLES) @(negedge clk);

        $display("numbers sent: %0d signed dec, %0d unsigned dec, %0d lower hex, %0d upper hex",
                 op_seen[i2a_pkg::OP_SDEC], op_seen[i2a_pkg::OP_UDEC],
                 op_seen[i2a_pkg::OP_HEXL], op_seen[i2a_pkg::OP_HEXU]);
        $display("characters checked: %0d, mismatches: %0d, with hold-offs and drain pauses",
                 chars_checked, mismatches);
        if (mismatches == 0 && expected_chars.size() == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
